// ===== sv/clc_pkg.sv =====
// Shared types, constants and helpers for the card number Luhn classifier.
package clc_pkg;

   localparam int CARD_WIDTH    = 63;
   localparam int SHIFT_WIDTH   = 64;
   localparam int BITS_PER_STEP = 4;
   localparam int NUM_DIGITS    = 20;
   localparam int CONVERT_STEPS = SHIFT_WIDTH / BITS_PER_STEP;
   localparam int SWEEP_STEPS   = NUM_DIGITS / 2;
   localparam int STEP_WIDTH    = $clog2(CONVERT_STEPS);
   localparam int COUNT_WIDTH   = 5;
   localparam int VERDICT_WIDTH = 2;
   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 8;

   typedef logic [3:0] digit_type;

   typedef enum logic [VERDICT_WIDTH-1:0] {
      VERDICT_INVALID = 2'd0,
      VERDICT_BRAND_A = 2'd1,
      VERDICT_BRAND_B = 2'd2,
      VERDICT_BRAND_C = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Per-cycle command to every digit cell.
   typedef struct packed {
      logic clear;
      logic convert;
      logic sweep;
   } cell_ctrl_type;

   // Luhn weight for a digit in a doubled position.
   function automatic logic [4:0] luhn_double(input digit_type d);
      logic [4:0] dbl;
      dbl = {d, 1'b0};
      if (dbl > 5'd9) begin
         dbl = dbl - 5'd9;
      end
      return dbl;
   endfunction

endpackage

// ===== sv/card_number_luhn_classifier.sv =====
// Top level of the card number classifier: control, digit chain and result register.
//
// Takes one 63-bit binary card number per word and returns one result word
// holding a brand verdict and the decimal digit count. The number is turned
// into BCD by a chain of twenty digit cells, four binary bits per cycle; the
// chain then shifts down two digits per cycle into a Luhn mod-10 accumulator
// that also tracks the digit count and leading two digits, and the leading
// pair and length then give the verdict. A new number is accepted only after
// the previous one has been converted, swept and classified. The result sits
// in an output register, so a new number is accepted while the previous
// result waits; a result is loaded only once the previous one has been taken,
// and the classify state holds for as long as that takes. Verdict: 0 invalid,
// 1 for leading digits 34 or 37, 2 for 51 to 55, 3 for 40 to 49; the number
// must also have 13, 15 or 16 digits and pass the Luhn check. Zero reports
// invalid with a count of zero.
module card_number_luhn_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [clc_pkg::REQ_DATA_WIDTH-1:0] req_tdata, // [62:0] card_number
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [clc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata  // [1:0] verdict, [6:2] digit_count
);
   import clc_pkg::*;

   state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [SHIFT_WIDTH-1:0] shift_ff, shift_in;
   logic [3:0]  acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   digit_type   lead_hi_ff, lead_hi_in, lead_lo_ff, lead_lo_in;
   digit_type   prev_ff, prev_in;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   cell_ctrl_type ctrl;
   logic      accept;
   logic [4:0] luhn_sum;
   logic [COUNT_WIDTH-1:0] pair_base;
   verdict_type verdict;
   logic      length_ok;

   logic [BITS_PER_STEP-1:0] carry [NUM_DIGITS];
   digit_type digits [NUM_DIGITS];

   // Digit chain: cell 0 takes the top input bits; each cell feeds its upper neighbor.
   assign carry[0] = {shift_ff[SHIFT_WIDTH-4], shift_ff[SHIFT_WIDTH-3],
                      shift_ff[SHIFT_WIDTH-2], shift_ff[SHIFT_WIDTH-1]};

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      digit_type down;
      if (i + 2 < NUM_DIGITS) begin : g_down
         assign down = digits[i+2];
      end else begin : g_top
         assign down = '0;
      end
      if (i + 1 < NUM_DIGITS) begin : g_link
         clc_digit_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .bits_in  (carry[i]),
            .bits_out (carry[i+1]),
            .down_in  (down),
            .digit_out(digits[i])
         );
      end else begin : g_last
         // Top cell never overflows: 63 bits fit in 19 digits.
         clc_digit_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .bits_in  (carry[i]),
            .bits_out (),
            .down_in  (down),
            .digit_out(digits[i])
         );
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Luhn sum of the current digit pair, kept below ten.
   always_comb begin
      luhn_sum = 5'(acc_ff) + 5'(digits[0]) + luhn_double(digits[1]);
      if (luhn_sum >= 5'd20) begin
         luhn_sum = luhn_sum - 5'd20;
      end else if (luhn_sum >= 5'd10) begin
         luhn_sum = luhn_sum - 5'd10;
      end
   end

   assign pair_base = {1'b0, step_ff} << 1;

   // Classify from the leading pair and length.
   always_comb begin
      length_ok = (count_ff == 5'd13) || (count_ff == 5'd15) || (count_ff == 5'd16);
      verdict   = VERDICT_INVALID;
      if (length_ok && (acc_ff == 4'd0)) begin
         if (lead_hi_ff == 4'd3 && (lead_lo_ff == 4'd4 || lead_lo_ff == 4'd7)) begin
            verdict = VERDICT_BRAND_A;
         end else if (lead_hi_ff == 4'd5 && lead_lo_ff >= 4'd1 && lead_lo_ff <= 4'd5) begin
            verdict = VERDICT_BRAND_B;
         end else if (lead_hi_ff == 4'd4) begin
            verdict = VERDICT_BRAND_C;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      shift_in       = shift_ff;
      acc_in         = acc_ff;
      count_in       = count_ff;
      lead_hi_in     = lead_hi_ff;
      lead_lo_in     = lead_lo_ff;
      prev_in        = prev_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_count_in   = rsp_count_ff;
      ctrl           = '0;

      // Drop the result once taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.clear = 1'b1;
               shift_in   = {1'b0, req_tdata[CARD_WIDTH-1:0]};
               step_in    = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.convert = 1'b1;
            shift_in     = shift_ff << BITS_PER_STEP;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(CONVERT_STEPS - 1)) begin
               step_in    = '0;
               acc_in     = '0;
               count_in   = '0;
               lead_hi_in = '0;
               lead_lo_in = '0;
               prev_in    = '0;
               state_in   = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // Advance the chain two digits; the last nonzero digit sets count and lead.
            ctrl.sweep = 1'b1;
            acc_in     = luhn_sum[3:0];
            prev_in    = digits[1];
            if (digits[1] != 4'd0) begin
               count_in   = pair_base + 5'd2;
               lead_hi_in = digits[1];
               lead_lo_in = digits[0];
            end else if (digits[0] != 4'd0) begin
               count_in   = pair_base + 5'd1;
               lead_hi_in = digits[0];
               lead_lo_in = prev_ff;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(SWEEP_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict;
               rsp_count_in   = count_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      shift_ff       <= shift_in;
      acc_ff         <= acc_in;
      count_ff       <= count_in;
      lead_hi_ff     <= lead_hi_in;
      lead_lo_ff     <= lead_lo_in;
      prev_ff        <= prev_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_verdict_ff};

endmodule

// ===== sv/clc_digit_cell.sv =====
// One BCD digit cell of the double-dabble and sweep chain.
module clc_digit_cell (
   input  logic                   clock,
   input  clc_pkg::cell_ctrl_type ctrl,
   input  logic [clc_pkg::BITS_PER_STEP-1:0] bits_in,
   output logic [clc_pkg::BITS_PER_STEP-1:0] bits_out,
   input  clc_pkg::digit_type     down_in,
   output clc_pkg::digit_type     digit_out
);
   import clc_pkg::*;

   digit_type digit_ff;
   digit_type digit_in;
   digit_type dabble;

   // Several add-3-then-shift steps per cycle, lowest neighbor feeding each step.
   always_comb begin
      digit_type adj;
      dabble   = digit_ff;
      bits_out = '0;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         adj         = (dabble >= 4'd5) ? dabble + 4'd3 : dabble;
         bits_out[s] = adj[3];
         dabble      = {adj[2:0], bits_in[s]};
      end
   end

   always_comb begin
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = dabble;
      end else if (ctrl.sweep) begin
         digit_in = down_in;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff;

endmodule
